// File: src/sts_pkg.sv
`timescale 1ns / 1ps

package sts_pkg;

    // default sizes of the table
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths
    localparam int IDX_W = 10;
    localparam int POS_W = 10;
    localparam int LEN_W = 11;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_TABLE_LENGTH = 3'd0;

    // slots in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

// File: src/sts_in_if.sv
`timescale 1ns / 1ps

interface sts_in_if
    import sts_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [IDX_W-1:0]              entry_index;
    logic signed [VALUE_WIDTH-1:0] entry_value;
    logic signed [VALUE_WIDTH-1:0] search_key;

    modport source (
        output valid,
        output operation,
        output entry_index,
        output entry_value,
        output search_key,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  entry_index,
        input  entry_value,
        input  search_key,
        output ready
    );

endinterface

// File: src/sts_out_if.sv
`timescale 1ns / 1ps

interface sts_out_if
    import sts_pkg::*;
();

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (
        output valid,
        output found,
        output position,
        input  ready
    );

    modport sink (
        input  valid,
        input  found,
        input  position,
        output ready
    );

endinterface

// File: src/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// search: a request waits in the queue until the back end is idle with no result pending, then
// the back end reads the first probe; each probe is a table read and compare in ST_STEP
// a search starts only once the last result is taken; one write per cycle while no search runs
// the single table read port paces the probes; a 2-slot queue takes requests meanwhile
// reset clears table_length and all control state; table contents stay undefined until written

module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    sts_in_if.sink            item,
    sts_out_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    localparam int CW = (NW > LEN_W) ? NW : LEN_W;

    logic [LEN_W-1:0] table_length_reg;
    logic [NW-1:0]    len_eff;

    logic                   cmd_valid;
    logic                   cmd_ready;
    logic                   cmd_op;
    logic [AW-1:0]          cmd_addr;
    logic [VALUE_WIDTH-1:0] cmd_data;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TABLE_LENGTH) ? APB_DW'(table_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_TABLE_LENGTH))
        begin
            table_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    // lengths beyond the table depth are clamped
    assign len_eff = (CW'(table_length_reg) > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                                : NW'(table_length_reg);

    sts_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd_op),
        .cmd_addr  (cmd_addr),
        .cmd_data  (cmd_data)
    );

    sts_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_op    (cmd_op),
        .cmd_addr  (cmd_addr),
        .cmd_data  (cmd_data),
        .table_len (len_eff),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .result    (result)
    );

    sts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// File: src/sts_ram.sv
`timescale 1ns / 1ps

module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sts_front.sv
`timescale 1ns / 1ps

module sts_front
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    sts_in_if.sink                         item,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output logic                           cmd_op,
    output logic [$clog2(TABLE_DEPTH)-1:0] cmd_addr,
    output logic [VALUE_WIDTH-1:0]         cmd_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic             op_q_reg   [QUEUE_DEPTH];
    logic [AW-1:0]    addr_q_reg [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0] data_q_reg [QUEUE_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic accept;
    logic in_range;
    logic push;
    logic pop;

    assign item.ready = (count_reg != CW'(QUEUE_DEPTH));
    assign accept     = item.valid && item.ready;

    // writes past the end of the table are dropped here
    assign in_range = (32'(item.entry_index) < TABLE_DEPTH);
    assign push     = accept && ((item.operation == OP_SEARCH) || in_range);
    assign pop      = cmd_valid && cmd_ready;

    assign cmd_valid = (count_reg != '0);
    assign cmd_op    = op_q_reg[rd_ptr_reg];
    assign cmd_addr  = addr_q_reg[rd_ptr_reg];
    assign cmd_data  = data_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // a search carries its key in the data slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q_reg[wr_ptr_reg]   <= item.operation;
            addr_q_reg[wr_ptr_reg] <= AW'(item.entry_index);
            data_q_reg[wr_ptr_reg] <= (item.operation == OP_SEARCH) ? item.search_key
                                                                    : item.entry_value;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("queue count lost a request");

endmodule

// File: src/sts_back.sv
`timescale 1ns / 1ps

module sts_back
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  logic                           cmd_op,
    input  logic [$clog2(TABLE_DEPTH)-1:0] cmd_addr,
    input  logic [VALUE_WIDTH-1:0]         cmd_data,
    input  logic [$clog2(TABLE_DEPTH):0]   table_len,
    output logic                           ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_waddr,
    output logic [VALUE_WIDTH-1:0]         ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_raddr,
    input  logic [VALUE_WIDTH-1:0]         ram_rdata,
    sts_out_if.source                      result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_STEP = 1'b1;

    logic state_reg, state_next;
    // search range is [lo, lim)
    logic [NW-1:0] lo_reg, lo_next;
    logic [NW-1:0] lim_reg, lim_next;
    logic [NW-1:0] mid_reg, mid_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;

    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic                          take;
    logic signed [VALUE_WIDTH-1:0] probe;
    logic                          hit;
    logic                          go_up;
    logic [NW-1:0]                 lo_step;
    logic [NW-1:0]                 lim_step;
    logic [NW-1:0]                 span;

    // a search needs the result register free, a write does not
    assign cmd_ready = (state_reg == ST_IDLE) && ((cmd_op == OP_WRITE) || !out_valid_reg);
    assign take      = cmd_valid && cmd_ready;

    assign ram_waddr = cmd_addr;
    assign ram_wdata = cmd_data;
    assign ram_raddr = mid_next[AW-1:0];

    assign probe    = $signed(ram_rdata);
    assign hit      = (probe == key_reg);
    assign go_up    = (key_reg > probe);
    assign lo_step  = go_up ? NW'(mid_reg + 1'b1) : lo_reg;
    assign lim_step = go_up ? lim_reg : mid_reg;
    assign span     = NW'(lim_step - lo_step - 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        lim_next       = lim_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !result.ready;
        found_next     = found_reg;
        pos_next       = pos_reg;
        ram_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd_op == OP_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        key_next = $signed(cmd_data);
                        if (table_len == '0)
                        begin
                            out_valid_next = 1'b1;
                            found_next     = 1'b0;
                            pos_next       = '0;
                        end
                        else
                        begin
                            lo_next    = '0;
                            lim_next   = table_len;
                            mid_next   = NW'(table_len - 1'b1) >> 1;
                            state_next = ST_STEP;
                        end
                    end
                end
            end
            ST_STEP:
            begin
                if (hit)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    pos_next       = POS_W'(mid_reg);
                    state_next     = ST_IDLE;
                end
                else if (lo_step >= lim_step)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    pos_next       = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    lo_next  = lo_step;
                    lim_next = lim_step;
                    mid_next = NW'(lo_step + (span >> 1));
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        lim_reg   <= lim_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.found    = found_reg;
    assign result.position = pos_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> !out_valid_reg)
        else $error("search running while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> ((lo_reg <= mid_reg) && (mid_reg < lim_reg)))
        else $error("probe outside the search range");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_STEP || $past(take)))
        else $error("result without a search");

endmodule

// File: test/sorted_table_binary_search_test.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_test;
    import sts_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int VW = VALUE_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam logic signed [VW-1:0] VALUE_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_answer_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sts_in_if #(.VALUE_WIDTH(VW)) item_ch ();
    sts_out_if result_ch ();

    sorted_table_binary_search #(
        .TABLE_DEPTH(DEPTH),
        .VALUE_WIDTH(VW)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // mirror of the block: table contents, which entries hold data, length register
    logic signed [VW-1:0] entry_table [DEPTH];
    bit                   entry_written [DEPTH];
    logic [LEN_W-1:0]     length_model;
    search_answer_t       pending_answers [$];

    int     error_count;
    bit     item_live;
    bit     sender_idle_on;
    bit     receiver_idle_on;
    int     hold_request;
    longint fill_base;
    longint fill_step;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic search_answer_t predict_search(input logic signed [VW-1:0] key);
        int             lo;
        int             hi;
        int             mid;
        int             len;
        search_answer_t answer;
        answer = '0;
        len = (int'(length_model) > DEPTH) ? DEPTH : int'(length_model);
        lo = 0;
        hi = len - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (entry_table[mid] == key)
            begin
                answer.found = 1'b1;
                answer.position = POS_W'(mid);
                return answer;
            end
            if (key > entry_table[mid])
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return answer;
    endfunction

    // ascending default content for entries that a search reaches before they were written
    function automatic logic signed [VW-1:0] fill_value(input int idx);
        return VW'(fill_base + longint'(idx) * fill_step);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                                input logic signed [VW-1:0] value,
                                input logic signed [VW-1:0] key);
        int gap;
        if (sender_idle_on && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 3);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.operation <= op;
        item_ch.entry_index <= idx;
        item_ch.entry_value <= value;
        item_ch.search_key <= key;
        item_live = 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        if (op == OP_WRITE)
        begin
            entry_table[idx] = value;
            entry_written[idx] = 1'b1;
        end
        else
            pending_answers.push_back(predict_search(key));
    endtask

    // valid stays high between back-to-back requests; it is lowered here and for the idle gaps in send_request
    task automatic stop_items();
        if (item_live)
        begin
            item_ch.valid <= 1'b0;
            item_live = 1'b0;
        end
    endtask

    task automatic wait_drain();
        stop_items();
        do @(posedge clk); while (pending_answers.size() != 0);
    endtask

    // writes give no result, so let the last ones settle before touching the register
    task automatic wait_idle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_length(input int len);
        logic [APB_DW-1:0] readback;
        wait_idle();
        apb_write(REG_TABLE_LENGTH, APB_DW'(len));
        length_model = LEN_W'(len);
        @(posedge clk);
        apb_read(REG_TABLE_LENGTH, readback);
        if (readback !== APB_DW'(len))
            report_mismatch("table_length readback", readback, len);
    endtask

    // walk the search path first and write any entry it would reach unwritten
    task automatic search_for(input logic signed [VW-1:0] key);
        int                   lo;
        int                   hi;
        int                   mid;
        logic signed [VW-1:0] probe;
        lo = 0;
        hi = ((int'(length_model) > DEPTH) ? DEPTH : int'(length_model)) - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (!entry_written[mid])
                send_request(OP_WRITE, IDX_W'(mid), fill_value(mid), VW'($urandom));
            probe = entry_table[mid];
            if (probe == key)
                break;
            if (key > probe)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        send_request(OP_SEARCH, IDX_W'($urandom), VW'($urandom), key);
    endtask

    task automatic write_sorted_entries(input int len);
        longint      cur;
        longint      cap;
        int unsigned step_cap;
        int          r;
        if (len == 0)
            return;
        r = $urandom;
        cur = ($urandom_range(0, 3) == 0) ? longint'(VALUE_MIN) : longint'(r);
        cap = (longint'(VALUE_MAX) - cur) / len;
        step_cap = int'(cap);
        if ($urandom_range(0, 2) == 0 && step_cap > 3)
            step_cap = 3;
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1 && $urandom_range(0, 4) == 0)
                cur = longint'(VALUE_MAX);
            send_request(OP_WRITE, IDX_W'(i), VW'(cur), VW'($urandom));
            if (step_cap != 0 && $urandom_range(0, 4) != 0)
                cur += $urandom_range(1, step_cap);
        end
    endtask

    function automatic logic signed [VW-1:0] pick_key(input int len);
        int                   sel;
        int                   idx;
        logic signed [VW-1:0] base;
        sel = $urandom_range(0, 99);
        idx = (len > 0) ? $urandom_range(0, len - 1) : 0;
        base = entry_written[idx] ? entry_table[idx] : fill_value(idx);
        if (len == 0 || sel >= 85)
            return VW'($urandom);
        if (sel < 45)
            return base;
        if (sel < 60)
            return base + 1;
        if (sel < 70)
            return base - 1;
        if (sel < 78)
            return VALUE_MIN;
        return VALUE_MAX;
    endfunction

    task automatic run_round(input int len, input int search_count);
        int noise_top;
        if (len < DEPTH)
            write_sorted_entries(len);
        else
        begin
            fill_step = $urandom_range(1, 4_000_000);
            fill_base = -(fill_step * DEPTH) / 2;
        end
        set_length(len);
        noise_top = (len + 8 > DEPTH - 1) ? DEPTH - 1 : len + 8;
        repeat (search_count)
        begin
            // an occasional stray write can break the ordering of the table
            if ($urandom_range(0, 9) == 0)
                send_request(OP_WRITE,
                             IDX_W'($urandom_range(0, 1) ? $urandom_range(0, DEPTH - 1)
                                                         : $urandom_range(0, noise_top)),
                             VW'($urandom), VW'($urandom));
            else
                search_for(pick_key(len));
            if ($urandom_range(0, 29) == 0)
                wait_drain();
        end
    endtask

    // result side: check each accepted result, then choose ready for the next cycle
    initial
    begin
        int             hold_left;
        int             stall_left;
        search_answer_t want;
        hold_left = 0;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch("result with no search waiting", result_ch.position, 0);
                else
                begin
                    want = pending_answers.pop_front();
                    if (result_ch.found !== want.found)
                        report_mismatch("found", result_ch.found, want.found);
                    if (result_ch.position !== want.position)
                        report_mismatch("position", result_ch.position, want.position);
                end
            end
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (receiver_idle_on && $urandom_range(0, 99) < 20)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic test_directed();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b1;
        // empty table right after reset
        search_for(32'sd0);
        send_request(OP_WRITE, IDX_W'(0), VALUE_MIN, 32'sd0);
        send_request(OP_WRITE, IDX_W'(1), -32'sd5, 32'sd0);
        send_request(OP_WRITE, IDX_W'(2), 32'sd0, 32'sd0);
        send_request(OP_WRITE, IDX_W'(3), 32'sd7, 32'sd0);
        send_request(OP_WRITE, IDX_W'(DEPTH - 1), VALUE_MAX, 32'sd0);
        set_length(4);
        search_for(VALUE_MIN);
        search_for(32'sd7);
        search_for(-32'sd6);
        search_for(32'sd0);
        search_for(VALUE_MAX);
        set_length(0);
        search_for(32'sd7);
        // full depth, the largest key walks to the last entry
        fill_step = 1000;
        fill_base = -512000;
        set_length(DEPTH);
        search_for(VALUE_MAX);
        set_length(1);
        search_for(VALUE_MIN);
    endtask

    task automatic test_sorted_rounds();
        int len;
        int sel;
        for (int r = 0; r < 12; r++)
        begin
            sender_idle_on = ($urandom_range(0, 3) != 0);
            receiver_idle_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 99);
            if (r == 5 || (sel >= 12 && sel < 16))
                len = DEPTH;
            else if (sel < 6)
                len = 0;
            else if (sel < 12)
                len = 1;
            else if (sel < 30)
                len = $urandom_range(2, 4);
            else
                len = $urandom_range(5, 40);
            run_round(len, $urandom_range(10, 18));
        end
    endtask

    task automatic test_receiver_hold();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b1;
        write_sorted_entries(32);
        set_length(32);
        // results back up while requests keep coming
        hold_request = 150;
        repeat (24) search_for(pick_key(32));
        wait_drain();
        repeat (8) search_for(pick_key(32));
    endtask

    task automatic test_full_rate();
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        run_round($urandom_range(8, 48), 30);
        run_round(DEPTH, 20);
    endtask

    initial
    begin
        error_count = 0;
        item_live = 1'b0;
        hold_request = 0;
        length_model = '0;
        fill_step = 1;
        fill_base = 0;
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.operation <= OP_WRITE;
        item_ch.entry_index <= '0;
        item_ch.entry_value <= '0;
        item_ch.search_key <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_TABLE_LENGTH;
        pwdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_sorted_rounds();
        test_receiver_hold();
        test_full_rate();

        wait_idle();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
src/sts_pkg.sv
src/sts_in_if.sv
src/sts_out_if.sv
src/sts_ram.sv
src/sts_front.sv
src/sts_back.sv
src/sorted_table_binary_search.sv
test/sorted_table_binary_search_test.sv
